/* rtl/playfair_affine_feistel_block_cipher_assert.svh */
// assertion macros shared by the checker
`ifndef PLAYFAIR_AFFINE_FEISTEL_BLOCK_CIPHER_ASSERT_SVH
`define PLAYFAIR_AFFINE_FEISTEL_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pfa_pkg.sv */
package pfa_pkg;

	localparam int unsigned NLANES = 8;
	localparam int unsigned KS_STEPS = 24;

	localparam logic [0:0] REG_KEY_ONE = 1'b0;
	localparam logic [0:0] REG_KEY_THREE = 1'b1;

	typedef enum logic {
		KS_IDLE,
		KS_BUILD
	} pfa_ks_state_t;

	typedef logic [15:0][3:0] pfa_nib16_t;

	typedef struct packed {
		pfa_nib16_t entry;
		pfa_nib16_t pos;
	} pfa_keytab_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	function automatic logic [31:0] sbox_word(input logic [31:0] x);
		logic [31:0] r;
		for (int i = 0; i < 4; i++) begin
			r[8*i +: 8] = SBOX[x[8*i +: 8]];
		end
		return r;
	endfunction

endpackage

/* rtl/pfa_keysched.sv */
module pfa_keysched
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] key,
	output pfa_keytab_t tab,
	output logic        busy
);

	pfa_ks_state_t   state_q, state_d;
	logic [4:0]      step_q;
	logic [15:0]     seen_q;
	logic [3:0]      cnt_q;
	logic [7:0][3:0] key_q;
	pfa_keytab_t     tab_q;
	logic [3:0]      v;
	logic            last;

	always_comb begin
		if (step_q < 5'd8) begin
			v = key_q[~step_q[2:0]];
		end else begin
			v = 4'(step_q - 5'd8);
		end
		last = (step_q == 5'(KS_STEPS - 1));
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b0;
		unique case (state_q)
			KS_IDLE: begin
				if (start) state_d = KS_BUILD;
			end
			KS_BUILD: begin
				busy = 1'b1;
				if (start) state_d = KS_BUILD;
				else if (last) state_d = KS_IDLE;
			end
			default: state_d = KS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			seen_q <= '0;
			cnt_q <= '0;
			key_q <= '0;
			for (int i = 0; i < 16; i++) begin
				tab_q.entry[i] <= 4'(i);
				tab_q.pos[i] <= 4'(i);
			end
		end else if (start) begin
			key_q <= key;
			step_q <= '0;
			seen_q <= '0;
			cnt_q <= '0;
		end else if (state_q == KS_BUILD) begin
			if (!seen_q[v]) begin
				seen_q[v] <= 1'b1;
				tab_q.entry[cnt_q] <= v;
				tab_q.pos[v] <= cnt_q;
				cnt_q <= cnt_q + 4'd1;
			end
			step_q <= step_q + 5'd1;
		end
	end

	assign tab = tab_q;

endmodule

/* rtl/pfa_lane.sv */
module pfa_lane
	import pfa_pkg::*;
(
	input  logic        dec,
	input  pfa_keytab_t tab,
	input  logic [7:0]  byte_in,
	output logic [7:0]  byte_out
);

	function automatic logic [3:0] aff_fwd(input logic [3:0] x);
		return x + {x[2:0], 1'b0} + 4'd5;
	endfunction

	function automatic logic [3:0] aff_inv(input logic [3:0] x);
		logic [3:0] y;
		y = x + 4'd11;
		return {y[0], 3'b000} + {y[2:0], 1'b0} + y;
	endfunction

	logic [7:0] a;
	logic [3:0] pa, pb, ia, ib, c, d;
	logic [1:0] ra, ca, rb, cb;

	always_comb begin
		a = dec ? {aff_inv(byte_in[7:4]), aff_inv(byte_in[3:0])} : byte_in;
		pa = tab.pos[a[7:4]];
		pb = tab.pos[a[3:0]];
		ra = pa[3:2];
		ca = pa[1:0];
		rb = pb[3:2];
		cb = pb[1:0];
		if (ra == rb) begin
			ia = {ra, dec ? ca - 2'd1 : ca + 2'd1};
			ib = {rb, dec ? cb - 2'd1 : cb + 2'd1};
		end else if (ca == cb) begin
			ia = {dec ? ra - 2'd1 : ra + 2'd1, ca};
			ib = {dec ? rb - 2'd1 : rb + 2'd1, cb};
		end else begin
			ia = {ra, cb};
			ib = {rb, ca};
		end
		c = tab.entry[ia];
		d = tab.entry[ib];
		byte_out = dec ? {c, d} : {aff_fwd(c), aff_fwd(d)};
	end

endmodule

/* rtl/pfa_feistel.sv */
module pfa_feistel
	import pfa_pkg::*;
(
	input  logic        dec,
	input  logic [31:0] key3,
	input  logic [63:0] blk_in,
	output logic [63:0] blk_out
);

	logic [31:0] f;

	always_comb begin
		f = sbox_word((dec ? blk_in[63:32] : blk_in[31:0]) ^ key3);
		if (dec) begin
			blk_out = {blk_in[31:0] ^ f, blk_in[63:32]};
		end else begin
			blk_out = {blk_in[31:0], blk_in[63:32] ^ f};
		end
	end

endmodule

/* rtl/playfair_affine_feistel_block_cipher.sv */
// channel   direction  handshake            payload
// in        to block   in_valid / in_stall  mode, block_in
// out       from block out_valid / out_stall block_out
// cfg       to block   cfg_we               cfg_idx, cfg_wdata
//
// one item per cycle while the input is not stalled: eight byte lanes and the round function are combinational,
// the result lands in the output register on the cycle after acceptance
// a key_one write rebuilds the key matrix in a sequencer; input stalls meanwhile
// reset gives the identity matrix and zero keys
// a stalled result holds the output register and stalls the input
module playfair_affine_feistel_block_cipher
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [63:0] block_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_out,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic            key_wr;
	logic            ks_busy;
	pfa_keytab_t     tab;
	logic [31:0]     key_three_q;
	logic [63:0]     fe_dec_out, fe_enc_out;
	logic [7:0][7:0] lane_in, lane_out;
	logic [63:0]     result;
	logic            acc;
	logic            out_valid_q;
	logic [63:0]     block_out_q;

	assign key_wr = cfg_we && (cfg_idx == REG_KEY_ONE);

	pfa_keysched u_ks (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (key_wr),
		.key    (cfg_wdata),
		.tab    (tab),
		.busy   (ks_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_three_q <= '0;
		end else if (cfg_we && (cfg_idx == REG_KEY_THREE)) begin
			key_three_q <= cfg_wdata;
		end
	end

	pfa_feistel u_fe_dec (
		.dec     (1'b1),
		.key3    (key_three_q),
		.blk_in  (block_in),
		.blk_out (fe_dec_out)
	);

	assign lane_in = mode ? fe_dec_out : block_in;

	for (genvar i = 0; i < NLANES; i++) begin : g_lane
		pfa_lane u_lane (
			.dec      (mode),
			.tab      (tab),
			.byte_in  (lane_in[i]),
			.byte_out (lane_out[i])
		);
	end

	pfa_feistel u_fe_enc (
		.dec     (1'b0),
		.key3    (key_three_q),
		.blk_in  (lane_out),
		.blk_out (fe_enc_out)
	);

	assign result = mode ? lane_out : fe_enc_out;

	assign in_stall = ks_busy || key_wr || (out_valid_q && out_stall);
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			block_out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign block_out = block_out_q;

endmodule

/* rtl/pfa_checker.sv */
`include "playfair_affine_feistel_block_cipher_assert.svh"

module pfa_checker
	import pfa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] block_out,
	input logic        cfg_we,
	input logic [0:0]  cfg_idx
);

	`PFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(block_out), "stalled item changed")
	`PFA_ASSERT_NEXT(a_key_stall, cfg_we && cfg_idx == REG_KEY_ONE, in_stall, "input open during key rebuild")
	`PFA_ASSERT_NEXT(a_acc_out, in_valid && !in_stall, out_valid, "accepted item gave no result")
	`PFA_ASSERT_NOW(a_full_stall, out_valid && out_stall, in_stall, "input open while result waits")

endmodule

bind playfair_affine_feistel_block_cipher pfa_checker u_pfa_checker (.*);
